@@ src/usvg_pkg.sv @@
// usvg_pkg: shared constants, types, sine table and helper functions for the
// UV sphere vertex generator. No dependencies.
`default_nettype none

package usvg_pkg;

    localparam int COUNT_BITS   = 10;
    localparam int CFG_DIV_BITS = 10;
    localparam int RADIUS_BITS  = 16;
    localparam int SINE_BITS    = 8;
    localparam int QSTEPS       = 1 << SINE_BITS;
    localparam int ANGLE_BITS   = SINE_BITS + 2;
    localparam int FRAC_BITS    = 17;
    localparam int QUO_BITS     = FRAC_BITS + 1;
    localparam int STEP_BITS    = $clog2(FRAC_BITS + 1);
    localparam int PROD_BITS    = 49;
    localparam int PA_SHIFT     = FRAC_BITS - SINE_BITS - 1;
    localparam int TA_SHIFT     = FRAC_BITS - SINE_BITS - 2;
    localparam int CFG_IDX_BITS = 2;
    localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RADIUS = 2'd0,
        REG_STACKS = 2'd1,
        REG_SLICES = 2'd2
    } cfg_reg_t;

    typedef logic signed [15:0] sine_t;
    typedef sine_t rom_t [QSTEPS+1];

    typedef struct packed {
        logic start;
        logic div_step;
        logic look;
        logic mul1;
        logic mul2;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } status_t;

    function automatic longint unsigned const_div(
        input longint unsigned n,
        input longint unsigned d
    );
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            if (r >= d)
            begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic rom_t build_rom();
        rom_t               rom;
        longint unsigned    x;
        longint unsigned    x2;
        longint unsigned    term;
        longint             sum;
        for (int i = 0; i <= QSTEPS; i++)
        begin
            x    = (64'd1686629713 * longint'(i) + longint'(QSTEPS >> 1)) >> SINE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 7; k++)
            begin
                term = (term * x2) >> 30;
                term = const_div(term, longint'((2 * k) * (2 * k + 1)));
                if (k[0])
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            rom[i] = sine_t'((longint'(sum) + 64'd32768) >> 16);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    function automatic sine_t sin_lookup(input logic [ANGLE_BITS-1:0] a);
        logic [1:0]           quad;
        logic [SINE_BITS-1:0] r;
        logic [SINE_BITS:0]   idx;
        sine_t                val;
        quad = a[ANGLE_BITS-1:SINE_BITS];
        r    = a[SINE_BITS-1:0];
        if (quad[0])
            idx = (SINE_BITS+1)'(QSTEPS) - {1'b0, r};
        else
            idx = {1'b0, r};
        val = SINE_ROM[idx];
        return quad[1] ? -val : val;
    endfunction

    function automatic logic signed [PROD_BITS-1:0] round_shift(
        input logic signed [PROD_BITS-1:0] v,
        input int                          sh
    );
        logic [PROD_BITS-1:0] mag;
        logic [PROD_BITS-1:0] q;
        mag = v[PROD_BITS-1] ? PROD_BITS'(-v) : PROD_BITS'(v);
        q   = (mag + (PROD_BITS'(1) << (sh - 1))) >> sh;
        return v[PROD_BITS-1] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [COUNT_BITS-1:0] eff_div(input logic [CFG_DIV_BITS-1:0] d);
        logic [COUNT_BITS-1:0] r;
        if (d == '0)
            r = COUNT_BITS'(1);
        else if (32'(d) > COUNT_MAX)
            r = COUNT_BITS'(COUNT_MAX);
        else
            r = COUNT_BITS'(d);
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/usvg_req_if.sv @@
// usvg_req_if: request channel (valid/ready plus restart bit).
// Depends on nothing.
`default_nettype none

interface usvg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

@@ src/usvg_vtx_if.sv @@
// usvg_vtx_if: vertex result channel (valid/ready plus vertex payload).
// Depends on nothing.
`default_nettype none

interface usvg_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic        [16:0] tex_u;
    logic        [16:0] tex_v;
    logic               last_vertex;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output norm_x, output norm_y, output norm_z,
                    output tex_u, output tex_v, output last_vertex, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z,
                  input norm_x, input norm_y, input norm_z,
                  input tex_u, input tex_v, input last_vertex, output ready);
endinterface

`default_nettype wire

@@ src/usvg_cfg_if.sv @@
// usvg_cfg_if: configuration write channel (valid/ready, index, data).
// Depends on nothing.
`default_nettype none

interface usvg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/usvg_ctrl.sv @@
// usvg_ctrl: sequencing state machine for one vertex word.
// Depends on usvg_pkg.
`default_nettype none

module usvg_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    output usvg_pkg::cmd_t        cmd,
    input  wire usvg_pkg::status_t status
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_LOOK = 6'b000100,
        ST_MUL1 = 6'b001000,
        ST_MUL2 = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_LOOK;
                else
                    cmd.div_step = 1'b1;
            end
            ST_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_accept_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == ST_DIV)
        else $error("accepted word did not start division");

    a_div_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && status.div_done |=> state_reg == ST_LOOK)
        else $error("division end not followed by lookup");

    a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN && status.out_free |=> state_reg == ST_IDLE)
        else $error("result load did not return to idle");

endmodule

`default_nettype wire

@@ src/usvg_dpath.sv @@
// usvg_dpath: config registers, vertex counters, shared-step dividers,
// sine lookup, multipliers and output register. Depends on usvg_pkg,
// usvg_cfg_if and usvg_vtx_if.
`default_nettype none

module usvg_dpath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire usvg_pkg::cmd_t    cmd,
    output usvg_pkg::status_t      status,
    input  wire logic              restart,
    usvg_cfg_if.sink               cfg,
    usvg_vtx_if.source             vertex
);

    localparam int CB = usvg_pkg::COUNT_BITS;
    localparam int PB = usvg_pkg::PROD_BITS;
    localparam int AB = usvg_pkg::ANGLE_BITS;
    localparam int QB = usvg_pkg::QUO_BITS;

    logic [usvg_pkg::RADIUS_BITS-1:0]  radius_reg;
    logic [usvg_pkg::CFG_DIV_BITS-1:0] stacks_cfg_reg;
    logic [usvg_pkg::CFG_DIV_BITS-1:0] slices_cfg_reg;

    logic [CB-1:0] stack_cnt_reg;
    logic [CB-1:0] slice_cnt_reg;
    logic [CB-1:0] stk_reg;
    logic [CB-1:0] slc_reg;
    logic          last_reg;

    logic [CB:0]   st_rem_reg;
    logic [CB:0]   sl_rem_reg;
    logic [QB-1:0] st_quo_reg;
    logic [QB-1:0] sl_quo_reg;
    logic [usvg_pkg::STEP_BITS-1:0] step_reg;

    usvg_pkg::sine_t sp_reg;
    usvg_pkg::sine_t cp_reg;
    usvg_pkg::sine_t snt_reg;
    usvg_pkg::sine_t ct_reg;
    logic [16:0]     tex_u_reg;
    logic [16:0]     tex_v_reg;

    logic signed [31:0]   px_reg;
    logic signed [31:0]   pz_reg;
    logic signed [32:0]   rcp_reg;
    logic signed [PB-1:0] rpx_reg;
    logic signed [PB-1:0] rpz_reg;

    logic out_valid_reg;

    logic [CB-1:0] stk;
    logic [CB-1:0] slc;
    logic [CB-1:0] st0;
    logic [CB-1:0] sl0;
    logic [CB-1:0] st_cur;
    logic [CB-1:0] sl_cur;
    logic [CB:0]   st_rem2;
    logic [CB:0]   sl_rem2;
    logic          st_bit;
    logic          sl_bit;
    logic [AB-1:0] pa;
    logic [AB-1:0] ta;
    logic [QB-1:0] st_sum_pa;
    logic [QB-1:0] sl_sum_ta;
    logic [QB-1:0] st_sum_v;
    logic [QB-1:0] sl_sum_u;
    logic signed [16:0] rad_s;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg     <= 16'd256;
            stacks_cfg_reg <= 10'd16;
            slices_cfg_reg <= 10'd32;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == usvg_pkg::REG_RADIUS)
                radius_reg <= cfg.data;
            else if (cfg.index == usvg_pkg::REG_STACKS)
                stacks_cfg_reg <= cfg.data[usvg_pkg::CFG_DIV_BITS-1:0];
            else if (cfg.index == usvg_pkg::REG_SLICES)
                slices_cfg_reg <= cfg.data[usvg_pkg::CFG_DIV_BITS-1:0];
        end
    end

    assign stk = usvg_pkg::eff_div(stacks_cfg_reg);
    assign slc = usvg_pkg::eff_div(slices_cfg_reg);

    always_comb
    begin
        st0 = restart ? '0 : stack_cnt_reg;
        sl0 = restart ? '0 : slice_cnt_reg;
        if (st0 > stk || sl0 > slc)
        begin
            st_cur = '0;
            sl_cur = '0;
        end
        else
        begin
            st_cur = st0;
            sl_cur = sl0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_cnt_reg <= '0;
            slice_cnt_reg <= '0;
        end
        else if (cmd.start)
        begin
            if (sl_cur < slc)
            begin
                slice_cnt_reg <= sl_cur + CB'(1);
                stack_cnt_reg <= st_cur;
            end
            else
            begin
                slice_cnt_reg <= '0;
                stack_cnt_reg <= (st_cur < stk) ? st_cur + CB'(1) : '0;
            end
        end
    end

    assign st_rem2 = {st_rem_reg[CB-1:0], 1'b0};
    assign sl_rem2 = {sl_rem_reg[CB-1:0], 1'b0};
    assign st_bit  = (st_rem2 >= {1'b0, stk_reg});
    assign sl_bit  = (sl_rem2 >= {1'b0, slc_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (cmd.start)
            step_reg <= '0;
        else if (cmd.div_step)
            step_reg <= step_reg + usvg_pkg::STEP_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            stk_reg    <= stk;
            slc_reg    <= slc;
            last_reg   <= (st_cur == stk) && (sl_cur == slc);
            st_quo_reg <= QB'(st_cur == stk);
            sl_quo_reg <= QB'(sl_cur == slc);
            st_rem_reg <= (st_cur == stk) ? '0 : {1'b0, st_cur};
            sl_rem_reg <= (sl_cur == slc) ? '0 : {1'b0, sl_cur};
        end
        else if (cmd.div_step)
        begin
            st_quo_reg <= {st_quo_reg[QB-2:0], st_bit};
            sl_quo_reg <= {sl_quo_reg[QB-2:0], sl_bit};
            st_rem_reg <= st_bit ? st_rem2 - {1'b0, stk_reg} : st_rem2;
            sl_rem_reg <= sl_bit ? sl_rem2 - {1'b0, slc_reg} : sl_rem2;
        end
    end

    assign st_sum_pa = st_quo_reg + QB'(1 << (usvg_pkg::PA_SHIFT - 1));
    assign sl_sum_ta = sl_quo_reg + QB'(1 << (usvg_pkg::TA_SHIFT - 1));
    assign st_sum_v  = st_quo_reg + QB'(1);
    assign sl_sum_u  = sl_quo_reg + QB'(1);
    assign pa = AB'(st_sum_pa >> usvg_pkg::PA_SHIFT);
    assign ta = AB'(sl_sum_ta >> usvg_pkg::TA_SHIFT);
    assign rad_s = $signed({1'b0, radius_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.look)
        begin
            sp_reg    <= usvg_pkg::sin_lookup(pa);
            cp_reg    <= usvg_pkg::sin_lookup(pa + AB'(usvg_pkg::QSTEPS));
            snt_reg   <= usvg_pkg::sin_lookup(ta);
            ct_reg    <= usvg_pkg::sin_lookup(ta + AB'(usvg_pkg::QSTEPS));
            tex_u_reg <= sl_sum_u[QB-1:1];
            tex_v_reg <= st_sum_v[QB-1:1];
        end
        if (cmd.mul1)
        begin
            px_reg  <= sp_reg * ct_reg;
            pz_reg  <= sp_reg * snt_reg;
            rcp_reg <= rad_s * cp_reg;
        end
        if (cmd.mul2)
        begin
            rpx_reg <= rad_s * px_reg;
            rpz_reg <= rad_s * pz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (vertex.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            vertex.pos_x       <= 17'(usvg_pkg::round_shift(rpx_reg, 28));
            vertex.pos_y       <= 17'(usvg_pkg::round_shift(PB'(rcp_reg), 14));
            vertex.pos_z       <= 17'(usvg_pkg::round_shift(rpz_reg, 28));
            vertex.norm_x      <= 16'(usvg_pkg::round_shift(PB'(px_reg), 14));
            vertex.norm_y      <= cp_reg;
            vertex.norm_z      <= 16'(usvg_pkg::round_shift(PB'(pz_reg), 14));
            vertex.tex_u       <= tex_u_reg;
            vertex.tex_v       <= tex_v_reg;
            vertex.last_vertex <= last_reg;
        end
    end

    assign vertex.valid    = out_valid_reg;
    assign status.div_done = (step_reg == usvg_pkg::STEP_BITS'(usvg_pkg::FRAC_BITS));
    assign status.out_free = !out_valid_reg || vertex.ready;

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= usvg_pkg::STEP_BITS'(usvg_pkg::FRAC_BITS))
        else $error("divider step count overran");

    a_last_tex: assert property (@(posedge clk) disable iff (!rst_n)
        vertex.valid && vertex.last_vertex |-> vertex.tex_u == 17'd65536
                                            && vertex.tex_v == 17'd65536)
        else $error("last vertex without full texture coordinates");

    a_norm_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        vertex.valid |-> vertex.norm_y <= 16'sd16384 && vertex.norm_y >= -16'sd16384)
        else $error("normal y out of unit range");

endmodule

`default_nettype wire

@@ src/uv_sphere_vertex_generator.sv @@
// uv_sphere_vertex_generator: top level of the UV sphere vertex generator.
// Depends on usvg_pkg, the channel interfaces, usvg_ctrl and usvg_dpath.
//
// Each request word yields one vertex word, walking slices inside stacks and
// wrapping after the last vertex; restart returns to the first vertex. One
// word is in flight at a time: after acceptance it passes through 17 restoring
// steps of the stack and slice dividers plus their check state, one sine
// lookup, two multiply stages and the output load, and the next request is
// taken once the controller is back in idle. The load waits while a previous
// vertex is still held in the output register. The result register lets the
// block take the next request while a finished vertex waits. Configuration
// writes are always ready and belong in idle time.
`default_nettype none

module uv_sphere_vertex_generator (
    input  wire logic  clk,
    input  wire logic  rst_n,
    usvg_req_if.sink   request,
    usvg_vtx_if.source vertex,
    usvg_cfg_if.sink   cfg
);

    usvg_pkg::cmd_t    cmd;
    usvg_pkg::status_t status;

    usvg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .cmd       (cmd),
        .status    (status)
    );

    usvg_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .restart (request.restart),
        .cfg     (cfg),
        .vertex  (vertex)
    );

endmodule

`default_nettype wire
